// ===== rtl/core/jpp_pkg.sv =====
// Package for the joystick packet parser: payload types and framing constants.
// No dependencies; compiled before the interfaces and the top level.
`default_nettype none

package jpp_pkg;

  typedef logic [7:0]        byte_t;
  typedef logic signed [7:0] axis_t;
  typedef logic [15:0]       word_t;
  typedef logic [2:0]        pos_t;

  // Framing and checksum constants
  localparam byte_t HEADER_BYTE = 8'hFF;
  localparam byte_t GOOD_SUM    = 8'hFF;
  localparam byte_t STICK_BIAS  = 8'h80;
  localparam int    DATA_BYTES  = 6;

  // Position codes: data byte index 0..5, checksum wait, header hunt
  localparam pos_t POS_FIRST = 3'd0;
  localparam pos_t POS_CHECK = 3'd6;
  localparam pos_t POS_HUNT  = 3'd7;

endpackage

`default_nettype wire

// ===== rtl/core/jpp_in_if.sv =====
// Input channel of the joystick packet parser: one received serial byte per request.
// Depends on jpp_pkg.
`default_nettype none

interface jpp_in_if;
  import jpp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/jpp_out_if.sv =====
// Output channel of the joystick packet parser: one decoded packet per request.
// Depends on jpp_pkg.
`default_nettype none

interface jpp_out_if;
  import jpp_pkg::*;

  logic  valid;
  logic  ready;
  axis_t left_vert;
  axis_t left_horiz;
  axis_t right_vert;
  axis_t right_horiz;
  word_t pan_word;
  word_t tilt_word;
  byte_t button_bits;
  byte_t extension;

  modport source (
    output valid, output left_vert, output left_horiz, output right_vert,
    output right_horiz, output pan_word, output tilt_word, output button_bits,
    output extension, input ready
  );
  modport sink (
    input valid, input left_vert, input left_horiz, input right_vert,
    input right_horiz, input pan_word, input tilt_word, input button_bits,
    input extension, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/joystick_packet_parser_top.sv =====
// Top level of the joystick packet parser: header hunt, byte collection,
// checksum test and result register. Depends on jpp_pkg, jpp_in_if, jpp_out_if.
//
//   channel   | direction | handshake     | payload
//   ----------+-----------+---------------+------------------------------------
//   in_ch     | in        | valid/ready   | rx_byte
//   out_ch    | out       | valid/ready   | sticks, pan, tilt, buttons, ext.
//   cfg       | in        | cfg_we        | cfg_wdata (swap_sticks)
//
// One byte is taken per cycle unless in_ch stalls; position and checksum
// change only in a cycle that accepts a byte. A good packet shows on out_ch
// the cycle after its checksum byte. The result register holds one packet;
// in_ch stalls only while that register is full and not being taken. Reset
// (rst, synchronous) starts the header hunt and empties the result register.
`default_nettype none

module joystick_packet_parser_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  jpp_in_if.sink    in_ch,
  jpp_out_if.source out_ch
);
  import jpp_pkg::*;

  logic  swap_sticks;
  pos_t  position;
  pos_t  position_next;
  byte_t sum_acc;
  byte_t sum_acc_next;
  byte_t payload [DATA_BYTES];
  logic  out_valid;
  logic  accept;
  logic  store_byte;
  logic  emit;
  byte_t b;

  assign b         = in_ch.rx_byte;
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept    = in_ch.valid && in_ch.ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_sticks <= 1'b0;
    end else if (cfg_we) begin
      swap_sticks <= cfg_wdata;
    end
  end

  // Framing: next position, running sum, byte store and good-packet test
  always_comb begin
    position_next = position;
    sum_acc_next  = sum_acc;
    store_byte    = 1'b0;
    emit          = 1'b0;
    if (position == POS_HUNT) begin
      if (b == HEADER_BYTE) begin
        position_next = POS_FIRST;
        sum_acc_next  = '0;
      end
    end else if (!(position == POS_FIRST && b == HEADER_BYTE)) begin
      sum_acc_next = sum_acc + b;
      if (position == POS_CHECK) begin
        position_next = POS_HUNT;
        emit          = (sum_acc_next == GOOD_SUM);
      end else begin
        position_next = position + 3'd1;
        store_byte    = 1'b1;
      end
    end
  end

  // Hold framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= POS_HUNT;
      sum_acc  <= '0;
    end else if (accept) begin
      position <= position_next;
      sum_acc  <= sum_acc_next;
    end
  end

  // Store data bytes
  always_ff @(posedge clk) begin
    if (accept && store_byte) begin
      payload[position] <= b;
    end
  end

  // Result valid: set on a good packet, drop when the request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load result fields
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      if (swap_sticks) begin
        out_ch.left_vert   <= axis_t'(payload[2] ^ STICK_BIAS);
        out_ch.left_horiz  <= axis_t'(payload[3] ^ STICK_BIAS);
        out_ch.right_vert  <= axis_t'(payload[0] ^ STICK_BIAS);
        out_ch.right_horiz <= axis_t'(payload[1] ^ STICK_BIAS);
      end else begin
        out_ch.left_vert   <= axis_t'(payload[0] ^ STICK_BIAS);
        out_ch.left_horiz  <= axis_t'(payload[1] ^ STICK_BIAS);
        out_ch.right_vert  <= axis_t'(payload[2] ^ STICK_BIAS);
        out_ch.right_horiz <= axis_t'(payload[3] ^ STICK_BIAS);
      end
      out_ch.pan_word    <= {payload[0], payload[1]};
      out_ch.tilt_word   <= {payload[2], payload[3]};
      out_ch.button_bits <= payload[4];
      out_ch.extension   <= payload[5];
    end
  end

  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire
